// ===== design/lss_pkg.sv =====
// shared types and codes for the lifo stack with search
package lss_pkg;

    localparam int VALUE_W  = 32;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;
    localparam int OP_W     = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2,
        OP_FIND = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic push;
        logic pop;
    } shift_ctrl_t;

endpackage

// ===== design/lss_cell.sv =====
// one stack cell: holds a word, shifts with its neighbors, compares against the key
module lss_cell
(
    input  logic                                 clk,
    input  lss_pkg::shift_ctrl_t                 ctrl,
    input  logic signed [lss_pkg::VALUE_W-1:0]   upper_data,
    input  logic signed [lss_pkg::VALUE_W-1:0]   lower_data,
    input  logic signed [lss_pkg::VALUE_W-1:0]   key,
    output logic signed [lss_pkg::VALUE_W-1:0]   data,
    output logic                                 match
);

    logic signed [lss_pkg::VALUE_W-1:0] data_reg;
    logic signed [lss_pkg::VALUE_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.push)
        begin
            data_next = upper_data;
        end
        else if (ctrl.pop)
        begin
            data_next = lower_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = (data_reg == key);

endmodule

// ===== design/lss_prio.sv =====
// priority encoder: lowest set match bit, i.e. the match nearest the top
module lss_prio
#(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
)
(
    input  logic [DEPTH-1:0] hits,
    output logic             found,
    output logic [IDX_W-1:0] idx
);

    always_comb
    begin
        idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                idx = IDX_W'(i);
            end
        end
    end

    assign found = |hits;

endmodule

// ===== design/lifo_stack_with_search.sv =====
// top level: shift-register stack of cells with per-cell search
// a result is registered on acceptance and appears on the output in the cycle after its request is accepted
// throughput: one request per cycle while the output is taken
// find uses one comparator per cell and a priority encoder over the occupied cells
// reset: clears the entry count and the output valid; cell words stay undefined
module lifo_stack_with_search
#(
    parameter int DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // data_out[31:0], position[35:32], count[40:36], zero pad
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    logic signed [lss_pkg::VALUE_W-1:0]  data_out_reg;
    logic signed [lss_pkg::VALUE_W-1:0]  data_out_next;
    logic [lss_pkg::POS_W-1:0]           position_reg;
    logic [lss_pkg::POS_W-1:0]           position_next;
    lss_pkg::status_t                    status_reg;
    lss_pkg::status_t                    status_next;
    logic [lss_pkg::COUNT_W-1:0]         count_out_reg;
    logic [lss_pkg::COUNT_W-1:0]         count_out_next;

    logic signed [lss_pkg::VALUE_W-1:0]  cell_data [DEPTH];
    logic [DEPTH-1:0]                    cell_match;
    logic [DEPTH-1:0]                    hits;
    logic                                found;
    logic [IDX_W-1:0]                    found_idx;
    logic [31:0]                         pos_wide;
    logic [31:0]                         cnt_wide;

    lss_pkg::shift_ctrl_t ctrl;
    lss_pkg::op_t         op;
    logic signed [lss_pkg::VALUE_W-1:0] value;
    logic                 accept;
    logic                 full;
    logic                 empty;

    assign op       = lss_pkg::op_t'(s_tuser);
    assign value    = s_tdata;
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg >= FULL_CNT);
    assign empty    = (count_reg == '0);

    assign ctrl.push = accept && (op == lss_pkg::OP_PUSH) && !full;
    assign ctrl.pop  = accept && (op == lss_pkg::OP_POP) && !empty;

    // cell 0 is the top of the stack
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [lss_pkg::VALUE_W-1:0] upper;
        logic signed [lss_pkg::VALUE_W-1:0] lower;

        if (i == 0)
        begin : g_top
            assign upper = value;
        end
        else
        begin : g_mid
            assign upper = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_bottom
            assign lower = cell_data[i];
        end
        else
        begin : g_above
            assign lower = cell_data[i+1];
        end

        lss_cell u_cell
        (
            .clk        (clk),
            .ctrl       (ctrl),
            .upper_data (upper),
            .lower_data (lower),
            .key        (value),
            .data       (cell_data[i]),
            .match      (cell_match[i])
        );

        // only occupied cells take part in the search
        assign hits[i] = cell_match[i] && (CNT_W'(i) < count_reg);
    end

    lss_prio #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_prio
    (
        .hits  (hits),
        .found (found),
        .idx   (found_idx)
    );

    assign pos_wide = 32'(found_idx);

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign cnt_wide = 32'(count_next);

    always_comb
    begin
        data_out_next  = '0;
        position_next  = '0;
        status_next    = lss_pkg::ST_OK;
        count_out_next = cnt_wide[lss_pkg::COUNT_W-1:0];
        case (op)
            lss_pkg::OP_PUSH:
            begin
                if (full)
                begin
                    status_next = lss_pkg::ST_FULL;
                end
            end
            lss_pkg::OP_POP, lss_pkg::OP_PEEK:
            begin
                if (empty)
                begin
                    status_next = lss_pkg::ST_EMPTY;
                end
                else
                begin
                    data_out_next = cell_data[0];
                end
            end
            lss_pkg::OP_FIND:
            begin
                if (found)
                begin
                    position_next = pos_wide[lss_pkg::POS_W-1:0];
                end
                else
                begin
                    status_next = lss_pkg::ST_NOT_FOUND;
                end
            end
            default:
            begin
                status_next = lss_pkg::ST_OK;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_out_reg  <= data_out_next;
            position_reg  <= position_next;
            status_reg    <= status_next;
            count_out_reg <= count_out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, count_out_reg, position_reg, data_out_reg};
    assign m_tuser  = status_reg;

endmodule

// ===== design/lss_checker.sv =====
// port-level checks for the lifo stack with search, bound to the top level
module lss_checker
#(
    parameter int DEPTH = 16
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);

    localparam logic [4:0] FULL_FIELD = 5'(DEPTH);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // full status, a dropped push, carries a count equal to the depth
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == lss_pkg::ST_FULL) |-> (m_tdata[40:36] == FULL_FIELD))
        else $error("full status with wrong count");

    // empty status carries zero data and zero count
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == lss_pkg::ST_EMPTY)
            |-> (m_tdata[40:36] == 5'd0) && (m_tdata[31:0] == 32'd0))
        else $error("empty status with data or count");

    // failed search carries zero data and position
    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == lss_pkg::ST_NOT_FOUND)
            |-> (m_tdata[35:0] == 36'd0))
        else $error("not found status with data or position");

    // a result always follows an accepted request
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted request gave no result");

endmodule

bind lifo_stack_with_search lss_checker #(.DEPTH(DEPTH)) u_lss_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
